### rtl/core/sha1s_pkg.sv
// Shared types and constants for the streaming SHA-1 hash block.
package sha1s_pkg;

  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned BLK_WORDS   = 16;
  localparam int unsigned BLK_AW      = 4;
  localparam int unsigned ROUNDS      = 80;

  typedef logic [31:0] word_t;
  typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

  localparam chain_t INIT_CHAIN = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

  localparam word_t K_CH  = 32'h5A827999;
  localparam word_t K_PAR = 32'h6ED9EBA1;
  localparam word_t K_MAJ = 32'h8F1BBCDC;
  localparam word_t K_LAST = 32'hCA62C1D6;

  localparam logic [1:0] OP_ABSORB   = 2'd0;
  localparam int unsigned OP_NO_BYTE = 1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [BLK_AW-1:0] LEN_HI_WORD = 4'd14;
  localparam logic [BLK_AW-1:0] LEN_LO_WORD = 4'd15;
  localparam logic [2:0] LAST_IDX = 3'd4;

  typedef struct packed {
    logic start;
  } cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

endpackage

### rtl/core/sha1s_in_if.sv
// Request channel: one message byte and/or a finish request.
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

### rtl/core/sha1s_out_if.sv
// Digest channel: one 32-bit digest word per transfer.
interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

### rtl/core/sha1s_core.sv
// SHA-1 compression: 80 single-cycle rounds fed from the block memory.
module sha1s_core import sha1s_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmp_ctl_t          ctl,
  input  chain_t            seed,
  input  word_t             rdata,
  output logic [BLK_AW-1:0] raddr,
  output cmp_stat_t         stat,
  output chain_t            work
);

  logic [6:0] rnd;
  logic       busy;
  logic       done;
  logic [BLK_WORDS-1:0][31:0] win;
  word_t a, b, c, d, e;
  word_t w, wx, f, k, t;

  always_comb begin
    wx = win[2] ^ win[7] ^ win[13] ^ win[15];
    w  = (rnd < 7'd16) ? rdata : {wx[30:0], wx[31]};
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_CH;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_PAR;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_MAJ;
    end else begin
      f = b ^ c ^ d;
      k = K_LAST;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w;
    raddr = ctl.start ? '0 : (rnd[BLK_AW-1:0] + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        if (rnd == 7'(ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        rnd <= rnd + 7'd1;
      end
    end
  end

  // working variables and schedule window, newest word at index 0
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= seed[0];
      b <= seed[1];
      c <= seed[2];
      d <= seed[3];
      e <= seed[4];
    end else if (busy) begin
      win <= {win[BLK_WORDS-2:0], w};
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign work = {e, d, c, b, a};

endmodule

### rtl/core/sha1_hash_stream.sv
// Top level of the streaming SHA-1 hash: byte gathering, padding, chaining and digest output.
//
// Each request carries one message byte, a finish, or both (op 0 absorbs, op 1 absorbs then
// finishes, op 2 or 3 finishes without a byte). Every 64th byte starts the compression, which
// holds off further requests: 80 rounds through a single round datapath that reads the
// message words from a 16-word block memory (one read a cycle, registered read data), then
// an add into the chaining words. A finish pads one byte per cycle, pausing while a full
// block is compressed, up to byte 56 (through an extra block when fewer than nine bytes are
// free), writes the two bit count words, runs a final compression, then offers digest words
// h0..h4 one per cycle as the sink takes them; the hash state then returns to its initial
// values. No request is taken until the fifth word has gone. The block memory needs no
// clearing after reset: every word is written before it is read.
module sha1_hash_stream import sha1s_pkg::*; (
  input logic           clk,
  input logic           rst,
  sha1s_in_if.sink      din,
  sha1s_out_if.source   dout
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PAD    = 6'b000010,
    ST_LEN_HI = 6'b000100,
    ST_LEN_LO = 6'b001000,
    ST_COMP   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t      state;
  chain_t      chain;
  logic [63:0] bits;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [2:0]  idx;
  logic        pad_first;
  logic        fin_pending;
  logic        final_block;

  logic        in_fire, out_fire, absorb;
  logic        ins_en;
  logic [7:0]  ins_byte;
  logic [5:0]  fill_inc;
  word_t       word_new;

  // block memory ports
  word_t              blk_mem [BLK_WORDS];
  logic               we;
  logic [BLK_AW-1:0]  waddr;
  word_t              wdata;
  logic [BLK_AW-1:0]  raddr;
  word_t              rdata;

  cmp_ctl_t  cctl;
  cmp_stat_t cstat;
  chain_t    work;

  assign din.ready = (state == ST_IDLE);
  assign in_fire   = din.valid && din.ready;
  assign out_fire  = dout.valid && dout.ready;
  assign absorb    = in_fire && !din.op[OP_NO_BYTE];

  // at most one byte enters the block per cycle, from the request or from the padding, none during a compression
  always_comb begin
    ins_en   = absorb || (state == ST_PAD);
    ins_byte = (state == ST_PAD) ? (pad_first ? PAD_MARK : 8'h00) : din.data_byte;
    fill_inc = fill + 6'd1;
    word_new = {acc, ins_byte};
    we    = (ins_en && (fill[1:0] == 2'b11)) || (state == ST_LEN_HI) || (state == ST_LEN_LO);
    waddr = fill[5:2];
    wdata = word_new;
    if (state == ST_LEN_HI) begin
      waddr = LEN_HI_WORD;
      wdata = bits[63:32];
    end else if (state == ST_LEN_LO) begin
      waddr = LEN_LO_WORD;
      wdata = bits[31:0];
    end
    // launch a compression on the last byte of a block or on writing the low bit count word
    cctl.start = (ins_en && (fill == FILL_LAST)) || (state == ST_LEN_LO);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      blk_mem[waddr] <= wdata;
    end
    rdata <= blk_mem[raddr];
  end

  sha1s_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .seed  (chain),
    .rdata (rdata),
    .raddr (raddr),
    .stat  (cstat),
    .work  (work)
  );

  always_ff @(posedge clk) begin
    if (ins_en) begin
      acc <= word_new[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chain       <= INIT_CHAIN;
      bits        <= '0;
      fill        <= '0;
      idx         <= '0;
      pad_first   <= 1'b0;
      fin_pending <= 1'b0;
      final_block <= 1'b0;
    end else begin
      if (ins_en) begin
        fill <= fill_inc;
      end
      if (absorb) begin
        bits <= bits + 64'd8;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            fin_pending <= (din.op != OP_ABSORB);
            pad_first   <= (din.op != OP_ABSORB);
            if (absorb && (fill == FILL_LAST)) begin
              state <= ST_COMP;
            end else if (din.op != OP_ABSORB) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (fill == FILL_LAST) begin
            state <= ST_COMP;
          end else if (fill_inc == LEN_FILL) begin
            state <= ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          state <= ST_LEN_LO;
        end
        ST_LEN_LO: begin
          final_block <= 1'b1;
          state       <= ST_COMP;
        end
        ST_COMP: begin
          if (cstat.done) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
              chain[i] <= chain[i] + work[i];
            end
            if (final_block) begin
              idx   <= '0;
              state <= ST_OUT;
            end else if (fin_pending) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            if (idx == LAST_IDX) begin
              // drop the message state and start afresh
              chain       <= INIT_CHAIN;
              bits        <= '0;
              fill        <= '0;
              fin_pending <= 1'b0;
              final_block <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign dout.valid       = (state == ST_OUT);
  assign dout.digest_word = chain[idx];
  assign dout.word_index  = idx;
  assign dout.last_word   = (idx == LAST_IDX);

  // the round unit only runs while the sequencer waits for it
  a_core_in_comp: assert property (@(posedge clk) disable iff (rst)
    (cstat.busy || cstat.done) |-> (state == ST_COMP))
    else $error("compression active outside the compression state");

  // the bit count always lands in the last two words of a block
  a_len_at_56: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN_HI) |-> (fill == LEN_FILL))
    else $error("length written at the wrong fill level");

  // taking the last digest word restores the initial hash state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_fire && dout.last_word) |=> ((state == ST_IDLE) && (chain == INIT_CHAIN)
                                      && (bits == 64'd0) && (fill == 6'd0)))
    else $error("hash state not restored after digest");

  // a new request is never taken while a digest is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !dout.valid)
    else $error("request taken during digest output");

endmodule

### tb/tb_sha1_hash_stream.sv
// Self-checking bench for the streaming SHA-1 block: request driver, digest monitor, hash predictor.
module tb_sha1_hash_stream;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycle limit for the watchdog.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Cycles run after the last digest word before the final report.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned RAND_REQUESTS = 310;
  localparam int unsigned RAND_MESSAGES = 6;

  typedef enum logic [1:0] {
    REQ_BYTE        = 2'd0,
    REQ_BYTE_FINISH = 2'd1,
    REQ_FINISH      = 2'd2,
    REQ_FINISH_ALT  = 2'd3
  } req_op_t;

  typedef struct packed {
    req_op_t    op;
    logic [7:0] data;
  } hash_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Initial chaining values and the four round-group constants of SHA-1.
  localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] K_ROUND [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                          32'hCA62C1D6};

  logic clk;
  logic rst;

  sha1s_in_if  din_if ();
  sha1s_out_if dout_if ();

  sha1_hash_stream dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Hash predictor state: chaining words, bit count, block buffer and fill level.
  // ---------------------------------------------------------------------------
  logic [31:0] chain_h [5];
  logic [63:0] bit_len;
  logic [31:0] blk_w [16];
  int          fill;
  int          msg_len;

  hash_req_t    req_q [$];     // requests waiting for the driver
  digest_beat_t digest_q [$];  // digest words predicted but not yet seen

  int unsigned err_cnt;
  int unsigned reqs_accepted;
  int unsigned msgs_hashed;
  int unsigned longest_msg;
  int unsigned words_checked;
  int unsigned cycle_cnt;
  bit          rand_phase;

  // Place one byte into the block buffer, big-endian within each word.
  function automatic void sha1_put_byte(int pos, logic [7:0] v);
    blk_w[pos / 4][(3 - (pos % 4)) * 8 +: 8] = v;
  endfunction

  // One 80-round compression of the block buffer, added into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUND[0];
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_ROUND[1];
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND[2];
      end else begin
        f = b ^ c ^ d;
        k = K_ROUND[3];
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void hash_state_init();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    bit_len = '0;
    fill    = 0;
    msg_len = 0;
  endfunction

  // Advance the predictor by one accepted request; a finish queues five digest words.
  function automatic void predict_request(logic [1:0] op, logic [7:0] data);
    logic [63:0] total;
    // Bit 1 of the op drops the byte; any nonzero op finishes (op 3 behaves as op 2).
    if (!op[1]) begin
      sha1_put_byte(fill, data);
      bit_len += 64'd8;
      msg_len++;
      fill = (fill + 1) % 64;
      if (fill == 0) sha1_compress();
    end
    if (op == REQ_BYTE) return;

    total = bit_len;
    sha1_put_byte(fill, 8'h80);
    for (int p = fill + 1; p < 64; p++) sha1_put_byte(p, 8'h00);
    // No room left for the length: compress this block and pad a further one.
    if (fill >= 56) begin
      sha1_compress();
      for (int i = 0; i < 16; i++) blk_w[i] = '0;
    end
    blk_w[14] = total[63:32];
    blk_w[15] = total[31:0];
    sha1_compress();

    for (int i = 0; i < 5; i++)
      digest_q.push_back('{word: chain_h[i], index: 3'(i), last: (i == 4)});
    msgs_hashed++;
    if (msg_len > longest_msg) longest_msg = msg_len;
    hash_state_init();
  endfunction

  task automatic queue_request(req_op_t op, logic [7:0] data);
    req_q.push_back('{op: op, data: data});
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. The
  // predictor is advanced on every accepted request.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_requests
    hash_req_t nxt;
    logic      nxt_valid;
    nxt_valid = din_if.valid;
    if (rst) begin
      nxt_valid = 1'b0;
      din_if.op <= REQ_BYTE;
      din_if.data_byte <= 8'h00;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (din_if.valid && din_if.ready) begin
        predict_request(din_if.op, din_if.data_byte);
        reqs_accepted++;
        nxt_valid = 1'b0;
      end
      // Hold an unaccepted request; otherwise idle out the gap or offer the next one.
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          nxt = req_q.pop_front();
          din_if.op <= nxt.op;
          din_if.data_byte <= nxt.data;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long unbroken stretch.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    din_if.valid <= nxt_valid;
  end

  // ---------------------------------------------------------------------------
  // Digest monitor and receiver stall pattern. Each accepted word is checked
  // field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  int  hold_cnt;
  int  stall_cnt;
  int  quiet_cnt;
  bit  long_hold_done;

  always @(posedge clk) begin : accept_digest
    digest_beat_t exp_beat;
    logic         nxt_ready;
    nxt_ready = 1'b1;
    if (rst) begin
      nxt_ready = 1'b0;
      hold_cnt = 0;
      stall_cnt = 0;
      quiet_cnt = 0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        if (digest_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected digest word %h (index %0d, last %b)", $time,
                   dout_if.digest_word, dout_if.word_index, dout_if.last_word);
        end else begin
          exp_beat = digest_q.pop_front();
          words_checked++;
          if (dout_if.digest_word !== exp_beat.word) begin
            err_cnt++;
            $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                     exp_beat.word, dout_if.digest_word);
          end
          if (dout_if.word_index !== exp_beat.index) begin
            err_cnt++;
            $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                     exp_beat.index, dout_if.word_index);
          end
          if (dout_if.last_word !== exp_beat.last) begin
            err_cnt++;
            $display("%0t: last_word mismatch: expected %b, actual %b", $time,
                     exp_beat.last, dout_if.last_word);
          end
        end
      end

      // Once in the random part, hold off the first digest offered for a long
      // stretch so that the block backs up and stalls its request side.
      if (!long_hold_done && rand_phase && dout_if.valid) begin
        hold_cnt = LONG_HOLD;
        long_hold_done = 1'b1;
      end

      if (hold_cnt > 0) begin
        hold_cnt--;
        nxt_ready = 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        nxt_ready = 1'b0;
      end else if (quiet_cnt > 0) begin
        quiet_cnt--;
      end else if ($urandom_range(0, 39) == 0) begin
        quiet_cnt = $urandom_range(40, 160);
      end else if ($urandom_range(0, 3) == 0) begin
        stall_cnt = $urandom_range(0, 5);
        nxt_ready = 1'b0;
      end
    end
    dout_if.ready <= nxt_ready;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d digest words outstanding", $time,
               cycle_cnt, digest_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed requests first, then random messages.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sel;
    int unsigned len;
    int unsigned tail;
    int unsigned rand_reqs;
    int unsigned rand_msgs;

    din_if.valid = 1'b0;
    din_if.op = REQ_BYTE;
    din_if.data_byte = 8'h00;
    dout_if.ready = 1'b0;
    rst = 1'b1;
    err_cnt = 0;
    reqs_accepted = 0;
    msgs_hashed = 0;
    longest_msg = 0;
    words_checked = 0;
    cycle_cnt = 0;
    rand_phase = 1'b0;
    long_hold_done = 1'b0;
    rand_reqs = 0;
    rand_msgs = 0;
    hash_state_init();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty message through both finish-only codes; the byte must be ignored.
    queue_request(REQ_FINISH, 8'hA5);
    queue_request(REQ_FINISH_ALT, 8'hFF);
    // Single-byte messages at the byte extremes, absorbed and finished at once.
    queue_request(REQ_BYTE_FINISH, 8'h00);
    queue_request(REQ_BYTE_FINISH, 8'hFF);
    // "abc"
    queue_request(REQ_BYTE, 8'h61);
    queue_request(REQ_BYTE, 8'h62);
    queue_request(REQ_BYTE_FINISH, 8'h63);
    // Byte then a finish-only request with a stray byte, both codes.
    queue_request(REQ_BYTE, 8'h80);
    queue_request(REQ_FINISH_ALT, 8'h7F);
    queue_request(REQ_BYTE, 8'h01);
    queue_request(REQ_FINISH, 8'hFE);
    queue_request(REQ_BYTE, 8'hFF);
    queue_request(REQ_BYTE, 8'h00);
    queue_request(REQ_BYTE, 8'h55);
    queue_request(REQ_BYTE_FINISH, 8'hAA);

    // Pause the sender until every predicted digest word has come back.
    while (req_q.size() != 0 || din_if.valid || digest_q.size() != 0) @(posedge clk);
    rand_phase = 1'b1;

    // Random messages: many short, many around the padding boundaries (one or
    // two blocks), and a few of any length up to 140 bytes.
    while (rand_reqs < RAND_REQUESTS || rand_msgs < RAND_MESSAGES) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)      len = $urandom_range(0, 20);
      else if (sel < 8) len = $urandom_range(52, 72);
      else              len = $urandom_range(0, 140);
      tail = $urandom_range(0, 2);
      // Finish either with the last byte, or with a separate finish-only request.
      for (int unsigned i = 0; i < len; i++) begin
        if (i == len - 1 && tail == 0)
          queue_request(REQ_BYTE_FINISH, 8'($urandom));
        else
          queue_request(REQ_BYTE, 8'($urandom));
        rand_reqs++;
      end
      if (len == 0 || tail != 0) begin
        queue_request($urandom_range(0, 1) ? REQ_FINISH_ALT : REQ_FINISH, 8'($urandom));
        rand_reqs++;
      end
      rand_msgs++;
    end

    while (req_q.size() != 0 || din_if.valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests forming %0d messages (longest %0d bytes),",
             reqs_accepted, msgs_hashed, longest_msg);
    $display("%0d digest words checked, %0d mismatches, %0d cycles", words_checked,
             err_cnt, cycle_cnt);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sha1s_pkg.sv
rtl/core/sha1s_in_if.sv
rtl/core/sha1s_out_if.sv
rtl/core/sha1s_core.sv
rtl/core/sha1_hash_stream.sv
tb/tb_sha1_hash_stream.sv
